FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the RTL file that carries checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk while rst is low.
`define PFRF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check prop at every rising edge of clk, reset included.
`define PFRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/pfrf_pkg.sv
// ----------------------------------------------------------------------------
// pfrf_pkg
// Shared types, codes and reset values of the audio frame ring FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package pfrf_pkg;

  localparam int RING_BYTES_DEF = 4096;

  localparam logic [6:0] MAX_CHUNK = 7'd64;

  // divider steps: one quotient bit per cycle over a 7-bit dividend
  localparam logic [2:0] DIV_STEPS = 3'd7;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    REG_RESERVE  = 3'd0,
    REG_FRAME    = 3'd1,
    REG_CHUNK    = 3'd2,
    REG_RESUME   = 3'd3,
    REG_RATE     = 3'd4,
    REG_CHANNELS = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_TAKE,
    ST_RD,
    ST_OUT
  } state_t;

  localparam logic [12:0] RESERVE_RST  = 13'd0;
  localparam logic [5:0]  FRAME_RST    = 6'd4;
  localparam logic [6:0]  CHUNK_RST    = 7'd64;
  localparam logic        RESUME_RST   = 1'b0;
  localparam logic [17:0] RATE_RST     = 18'd48000;
  localparam logic [3:0]  CHANNELS_RST = 4'd2;

endpackage

`default_nettype wire

FILE: src/pfrf_ring_mem.sv
// ----------------------------------------------------------------------------
// pfrf_ring_mem
// Byte ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfrf_ring_mem #(
  parameter int DEPTH = pfrf_pkg::RING_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/pfrf_frame_div.sv
// ----------------------------------------------------------------------------
// pfrf_frame_div
// Restoring divider, one quotient bit per cycle: whole frames in a byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module pfrf_frame_div (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [6:0] dividend,
  input  wire logic [5:0] divisor,
  output logic            done,
  output logic      [6:0] quotient
);

  logic       busy;
  logic [2:0] cnt;
  logic [5:0] rem;
  logic [5:0] dsr;
  logic [6:0] rem_try;
  logic       fits;

  assign rem_try = {rem, quotient[6]};
  assign fits    = rem_try >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= pfrf_pkg::DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 3'd1;
        if (cnt == 3'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so six bits hold it
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? 6'(rem_try - {1'b0, dsr}) : rem_try[5:0];
      quotient <= {quotient[5:0], fits};
    end
  end

endmodule

`default_nettype wire

FILE: src/pcm_frame_ring_fifo.sv
// ----------------------------------------------------------------------------
// pcm_frame_ring_fifo
// Audio byte FIFO on a power-of-two ring with frame-aligned chunk pops.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries func and in_byte: a push stores
// one byte, a pop drains whole frames as one chunk of bytes.
// Output channel (out_valid/out_ready) carries one result per transfer; every
// result reports fill level, producer_full and the prefill target.
// Push: one result, registered in the next cycle. Pushes go one per cycle while the
// output side keeps up; the ring never refuses a push and overwrites.
// Pop: one result for an empty or disabled pop, registered in the next cycle. Otherwise
// the frame divider runs (ST_DIV), the take is sized (ST_TAKE), then each chunk byte
// takes a ring read (ST_RD) and then an output load (ST_OUT).
// The single read port of the ring sets the per-byte pace.
// in_ready is low while a pop is being emitted.
// A stalled receiver holds the output register; nothing is dropped, and the
// sequencer waits for the slot before loading the next byte.
// Reset (rst, synchronous) clears the counts and loads the register defaults;
// ring contents stay undefined until written. No clearing pass is needed.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pcm_frame_ring_fifo #(
  parameter int RING_BYTES = pfrf_pkg::RING_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [17:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  out_byte,
  output logic             is_padding,
  output logic             last,
  output logic      [6:0]  frames_taken,
  output logic             producer_full,
  output logic      [12:0] fill_level,
  output logic      [11:0] prefill_target
);

  localparam int AW = $clog2(RING_BYTES);
  localparam int CW = AW + 1;
  localparam int WW = (CW > 13) ? CW : 13;

  // configuration registers
  logic [12:0] reserve_bytes;
  logic [5:0]  frame_size;
  logic [6:0]  chunk_size;
  logic        resume_mode;
  logic [17:0] rate_hz;
  logic [3:0]  channel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserve_bytes <= pfrf_pkg::RESERVE_RST;
      frame_size    <= pfrf_pkg::FRAME_RST;
      chunk_size    <= pfrf_pkg::CHUNK_RST;
      resume_mode   <= pfrf_pkg::RESUME_RST;
      rate_hz       <= pfrf_pkg::RATE_RST;
      channel_count <= pfrf_pkg::CHANNELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pfrf_pkg::REG_RESERVE:  reserve_bytes <= cfg_wdata[12:0];
        pfrf_pkg::REG_FRAME:    frame_size    <= cfg_wdata[5:0];
        pfrf_pkg::REG_CHUNK:    chunk_size    <= cfg_wdata[6:0];
        pfrf_pkg::REG_RESUME:   resume_mode   <= cfg_wdata[0];
        pfrf_pkg::REG_RATE:     rate_hz       <= cfg_wdata;
        pfrf_pkg::REG_CHANNELS: channel_count <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  pfrf_pkg::state_t state, state_next;

  logic [CW-1:0] wcount;
  logic [CW-1:0] rcount;
  logic [CW-1:0] base_q;
  logic [6:0]    chunk_q;
  logic [6:0]    take_q;
  logic [6:0]    frames_q;
  logic [6:0]    k_q;

  logic          out_free;
  logic          accept;
  logic          is_push;
  logic [CW-1:0] used;
  logic [CW-1:0] used_push;
  logic [WW-1:0] used_ext;
  logic [6:0]    chunk_eff;
  logic [6:0]    div_dividend;
  logic          pop_empty;
  logic          k_data;
  logic          k_last;

  // control strobes from the output decoder
  logic mem_we;
  logic mem_re;
  logic div_start;
  logic load_out;
  logic size_take;
  logic advance;

  // result being loaded
  logic [7:0]    res_byte;
  logic          res_pad;
  logic          res_last;
  logic [6:0]    res_frames;
  logic [CW-1:0] res_used;

  logic          div_done;
  logic [6:0]    div_quot;
  logic [6:0]    take_prod;
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;

  assign out_free  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_push   = func == pfrf_pkg::FUNC_PUSH;
  assign used      = wcount - rcount;
  assign used_push = wcount + CW'(1) - rcount;
  assign used_ext  = WW'(used);
  assign chunk_eff = (chunk_size > pfrf_pkg::MAX_CHUNK) ? pfrf_pkg::MAX_CHUNK : chunk_size;
  assign pop_empty = (used == '0) || (frame_size == '0) || (chunk_eff == '0);
  // min(used, chunk) / frame gives the clamped frame count directly
  assign div_dividend = (used_ext < WW'(chunk_eff)) ? used_ext[6:0] : chunk_eff;
  // the take never exceeds the chunk, so seven bits hold it
  assign take_prod = div_quot * 7'(frame_size);
  assign k_data    = k_q < take_q;
  assign k_last    = 7'(k_q + 7'd1) == chunk_q;
  assign rd_addr   = AW'(base_q + CW'(k_q));

  pfrf_frame_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (frame_size),
    .done     (div_done),
    .quotient (div_quot)
  );

  pfrf_ring_mem #(
    .DEPTH (RING_BYTES),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wcount[AW-1:0]),
    .wdata (in_byte),
    .re    (mem_re),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pfrf_pkg::ST_IDLE: begin
        if (accept && !is_push && !pop_empty) begin
          state_next = pfrf_pkg::ST_DIV;
        end
      end
      pfrf_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = pfrf_pkg::ST_TAKE;
        end
      end
      pfrf_pkg::ST_TAKE: state_next = pfrf_pkg::ST_RD;
      pfrf_pkg::ST_RD:   state_next = pfrf_pkg::ST_OUT;
      pfrf_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = k_last ? pfrf_pkg::ST_IDLE : pfrf_pkg::ST_RD;
        end
      end
      default: state_next = pfrf_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    size_take  = 1'b0;
    advance    = 1'b0;
    res_byte   = '0;
    res_pad    = 1'b0;
    res_last   = 1'b1;
    res_frames = '0;
    res_used   = used;
    unique case (state)
      pfrf_pkg::ST_IDLE: begin
        // hold off transfers until reset is released
        in_ready = out_free && !rst;
        if (accept) begin
          if (is_push) begin
            mem_we   = 1'b1;
            load_out = 1'b1;
            res_used = used_push;
          end else if (pop_empty) begin
            load_out = 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      pfrf_pkg::ST_DIV: ;
      pfrf_pkg::ST_TAKE: size_take = 1'b1;
      pfrf_pkg::ST_RD:   mem_re = 1'b1;
      pfrf_pkg::ST_OUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          advance    = 1'b1;
          res_byte   = k_data ? rd_data : 8'd0;
          res_pad    = !k_data;
          res_last   = k_last;
          res_frames = frames_q;
        end
      end
      default: ;
    endcase
  end

  // producer-full: threshold saturates at zero when reserve covers the ring
  logic [WW-1:0] res_used_ext;
  logic [WW-1:0] reserve_ext;
  logic [WW-1:0] cap_ext;
  logic [WW-1:0] full_thr;
  logic          res_full;

  assign res_used_ext = WW'(res_used);
  assign reserve_ext  = WW'(reserve_bytes);
  assign cap_ext      = WW'(RING_BYTES);
  assign full_thr     = (reserve_ext >= cap_ext) ? '0 : cap_ext - reserve_ext;
  assign res_full     = res_used_ext > full_thr;

  // prefill target, capped at half the ring
  logic [21:0] rate_ch;
  logic [22:0] pre_raw;
  logic [11:0] pre_cap;

  assign rate_ch = 22'(rate_hz) * 22'(channel_count);
  assign pre_raw = resume_mode ? 23'({chunk_size, 1'b0}) : {rate_ch, 1'b0};
  assign pre_cap = (pre_raw > 23'(RING_BYTES / 2)) ? 12'(RING_BYTES / 2) : pre_raw[11:0];

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfrf_pkg::ST_IDLE;
      wcount    <= '0;
      rcount    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (mem_we) begin
        wcount <= wcount + CW'(1);
      end
      if (size_take) begin
        rcount <= rcount + CW'(take_prod);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pop bookkeeping
  always_ff @(posedge clk) begin
    if (div_start) begin
      base_q  <= rcount;
      chunk_q <= chunk_eff;
    end
    if (size_take) begin
      take_q   <= take_prod;
      frames_q <= div_quot;
      k_q      <= '0;
    end else if (advance) begin
      k_q <= k_q + 7'd1;
    end
  end

  // output register: hold while stalled
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte       <= res_byte;
      is_padding     <= res_pad;
      last           <= res_last;
      frames_taken   <= res_frames;
      producer_full  <= res_full;
      fill_level     <= res_used_ext[12:0];
      prefill_target <= pre_cap;
    end
  end

  `PFRF_ASSERT(a_rcount_moves_on_take, clk, rst, (state != pfrf_pkg::ST_TAKE) |=> $stable(rcount), "read count moved outside take sizing")
  `PFRF_ASSERT(a_ring_write_idle_only, clk, rst, (state != pfrf_pkg::ST_IDLE) |-> !mem_we, "ring written during a pop")
  `PFRF_ASSERT(a_take_fits_chunk, clk, rst, (state == pfrf_pkg::ST_RD) |-> (take_q <= chunk_q), "frames taken exceed the chunk")

endmodule

`default_nettype wire

FILE: sim/pcm_frame_ring_fifo_tb.sv
// ----------------------------------------------------------------------------
// pcm_frame_ring_fifo_tb
// Self-checking bench for the audio frame ring FIFO. A local ring mirror
// predicts each push and pop chunk byte for byte. Directed tests cover the
// reset defaults, frame clamping, empty pops, oversized chunks, the reserve
// threshold and the prefill target. Random segments follow under changing
// register settings. Both handshake sides gap at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_frame_ring_fifo_tb;

  localparam int          RING         = pfrf_pkg::RING_BYTES_DEF;
  localparam int          CYCLE_LIMIT  = 4_000_000;
  localparam int          SETTLE       = 8;
  localparam int          SEG_ITEMS    = 38;
  localparam int          SEG_COUNT    = 10;
  localparam logic [2:0]  REG_NONE_LO  = 3'd6;
  localparam logic [2:0]  REG_NONE_HI  = 3'd7;

  typedef struct packed {
    logic [7:0]  byte_val;
    logic        pad;
    logic        last_flag;
    logic [6:0]  frames;
    logic        full;
    logic [12:0] fill;
    logic [11:0] prefill;
  } fifo_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [17:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = pfrf_pkg::FUNC_PUSH;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        is_padding;
  logic        last;
  logic [6:0]  frames_taken;
  logic        producer_full;
  logic [12:0] fill_level;
  logic [11:0] prefill_target;

  // ring mirror and register shadow
  logic [7:0]  ring_mirror [RING];
  logic [12:0] wr_cnt = '0;
  logic [12:0] rd_cnt = '0;
  logic [12:0] reserve_r  = pfrf_pkg::RESERVE_RST;
  logic [5:0]  frame_r    = pfrf_pkg::FRAME_RST;
  logic [6:0]  chunk_r    = pfrf_pkg::CHUNK_RST;
  logic        resume_r   = pfrf_pkg::RESUME_RST;
  logic [17:0] rate_r     = pfrf_pkg::RATE_RST;
  logic [3:0]  channels_r = pfrf_pkg::CHANNELS_RST;

  fifo_result_t bytes_due[$];
  int           error_count = 0;
  int           cycle_count = 0;

  pcm_frame_ring_fifo dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .is_padding     (is_padding),
    .last           (last),
    .frames_taken   (frames_taken),
    .producer_full  (producer_full),
    .fill_level     (fill_level),
    .prefill_target (prefill_target)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** pcm_frame_ring_fifo: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [12:0] fill_now();
    return wr_cnt - rd_cnt;
  endfunction

  function automatic logic [11:0] prefill_bytes();
    longint unsigned p;
    if (resume_r)
      p = longint'(chunk_r) * 2;
    else
      p = longint'(rate_r) * longint'(channels_r) * 2;
    if (p > RING / 2)
      p = RING / 2;
    return p[11:0];
  endfunction

  task automatic queue_result(logic [7:0] b, logic pad, logic lst, logic [6:0] frm);
    fifo_result_t r;
    int unsigned  used;
    int unsigned  thr;
    used = fill_now();
    thr = (reserve_r >= RING) ? 0 : RING - reserve_r;
    r.byte_val  = b;
    r.pad       = pad;
    r.last_flag = lst;
    r.frames    = frm;
    r.full      = (used > thr);
    r.fill      = used[12:0];
    r.prefill   = prefill_bytes();
    bytes_due.push_back(r);
  endtask

  task automatic predict_fifo_op(pfrf_pkg::func_t f, logic [7:0] b);
    int unsigned chunk;
    int unsigned used;
    int unsigned frames;
    int unsigned take;
    logic [12:0] base;
    if (f == pfrf_pkg::FUNC_PUSH) begin
      ring_mirror[wr_cnt[11:0]] = b;
      wr_cnt = wr_cnt + 13'd1;
      queue_result(8'd0, 1'b0, 1'b1, 7'd0);
      return;
    end
    chunk = (chunk_r > pfrf_pkg::MAX_CHUNK) ? pfrf_pkg::MAX_CHUNK : chunk_r;
    used = fill_now();
    if (used == 0 || frame_r == 0 || chunk == 0) begin
      queue_result(8'd0, 1'b0, 1'b1, 7'd0);
      return;
    end
    frames = used / frame_r;
    if (frames > chunk / frame_r)
      frames = chunk / frame_r;
    take = frames * frame_r;
    base = rd_cnt;
    rd_cnt = rd_cnt + take[12:0];
    for (int unsigned k = 0; k < chunk; k++) begin
      if (k < take)
        queue_result(ring_mirror[(base + k) % RING], 1'b0, k + 1 == chunk, frames[6:0]);
      else
        queue_result(8'd0, 1'b1, k + 1 == chunk, frames[6:0]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_item(pfrf_pkg::func_t f, logic [7:0] b);
    int gap;
    gap = int'($urandom_range(0, 17));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    predict_fifo_op(f, b);
  endtask

  // hold the sender until every predicted byte has been taken
  task automatic settle_results();
    in_valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [17:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      pfrf_pkg::REG_RESERVE:  reserve_r  = val[12:0];
      pfrf_pkg::REG_FRAME:    frame_r    = val[5:0];
      pfrf_pkg::REG_CHUNK:    chunk_r    = val[6:0];
      pfrf_pkg::REG_RESUME:   resume_r   = val[0];
      pfrf_pkg::REG_RATE:     rate_r     = val[17:0];
      pfrf_pkg::REG_CHANNELS: channels_r = val[3:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_random(int n);
    repeat (n) send_item(pfrf_pkg::FUNC_PUSH, 8'($urandom_range(0, 255)));
  endtask

  task automatic pop_chunk();
    send_item(pfrf_pkg::FUNC_POP, 8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    fifo_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (bytes_due.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual byte %0d fill %0d",
                 $time, out_byte, fill_level);
        error_count++;
      end else begin
        want = bytes_due.pop_front();
        check_field("out_byte", want.byte_val, out_byte);
        check_field("is_padding", want.pad, is_padding);
        check_field("last", want.last_flag, last);
        check_field("frames_taken", want.frames, frames_taken);
        check_field("producer_full", want.full, producer_full);
        check_field("fill_level", want.fill, fill_level);
        check_field("prefill_target", want.prefill, prefill_target);
      end
    end
  end

  // receiver: stall a random number of cycles before each transfer
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = int'($urandom_range(0, 17));
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_defaults();
    pop_chunk();                      // empty ring
    send_item(pfrf_pkg::FUNC_PUSH, 8'h00);
    send_item(pfrf_pkg::FUNC_PUSH, 8'hFF);
    send_item(pfrf_pkg::FUNC_PUSH, 8'h5A);
    send_item(pfrf_pkg::FUNC_PUSH, 8'hA5);
    pop_chunk();                      // one frame, rest padding
    settle_results();
  endtask

  task automatic test_frame_clamp();
    write_reg(pfrf_pkg::REG_FRAME, 18'd3);
    write_reg(pfrf_pkg::REG_CHUNK, 18'd4);
    push_random(7);
    pop_chunk();                      // two frames buffered, one fits
    settle_results();
    write_reg(pfrf_pkg::REG_FRAME, 18'd5);
    pop_chunk();                      // less than one frame buffered
    settle_results();
    write_reg(pfrf_pkg::REG_FRAME, 18'd3);
    write_reg(pfrf_pkg::REG_CHUNK, 18'd2);
    pop_chunk();                      // frame wider than chunk: all padding
    settle_results();
  endtask

  task automatic test_empty_pops();
    write_reg(pfrf_pkg::REG_FRAME, 18'd0);
    pop_chunk();
    settle_results();
    write_reg(pfrf_pkg::REG_FRAME, 18'd1);
    write_reg(pfrf_pkg::REG_CHUNK, 18'd0);
    pop_chunk();
    settle_results();
  endtask

  task automatic test_oversized_chunk();
    write_reg(pfrf_pkg::REG_FRAME, 18'd2);
    write_reg(pfrf_pkg::REG_CHUNK, 18'd127);
    write_reg(pfrf_pkg::REG_RESUME, 18'd1);
    pop_chunk();                      // saturates to 64, prefill uses 127
    settle_results();
  endtask

  task automatic test_reserve();
    write_reg(pfrf_pkg::REG_RESERVE, 18'd8191);
    send_item(pfrf_pkg::FUNC_PUSH, 8'($urandom_range(0, 255)));
    settle_results();
    write_reg(pfrf_pkg::REG_RESERVE, 18'd4096);
    send_item(pfrf_pkg::FUNC_PUSH, 8'($urandom_range(0, 255)));
    settle_results();
    write_reg(pfrf_pkg::REG_RESERVE, 18'd4095);
    send_item(pfrf_pkg::FUNC_PUSH, 8'($urandom_range(0, 255)));
    settle_results();
    // unmapped indexes must leave every register alone
    write_reg(REG_NONE_LO, 18'h3FFFF);
    write_reg(REG_NONE_HI, 18'h00000);
    write_reg(pfrf_pkg::REG_RESERVE, 18'd0);
  endtask

  task automatic test_prefill();
    write_reg(pfrf_pkg::REG_FRAME, 18'd1);
    write_reg(pfrf_pkg::REG_CHUNK, 18'd1);
    write_reg(pfrf_pkg::REG_RESUME, 18'd0);
    write_reg(pfrf_pkg::REG_RATE, 18'd0);
    pop_chunk();
    settle_results();
    write_reg(pfrf_pkg::REG_RATE, 18'h3FFFF);
    write_reg(pfrf_pkg::REG_CHANNELS, 18'd15);
    pop_chunk();                      // capped at half the ring
    settle_results();
    write_reg(pfrf_pkg::REG_RATE, 18'd1000);
    write_reg(pfrf_pkg::REG_CHANNELS, 18'd1);
    pop_chunk();
    settle_results();
    write_reg(pfrf_pkg::REG_RESUME, 18'd1);
    pop_chunk();
    settle_results();
  endtask

  task automatic shuffle_setup();
    logic [17:0] v;
    case ($urandom_range(0, 4))
      0: v = 18'd0;
      1: v = 18'd4095;
      2: v = 18'd4096;
      3: v = 18'd8191;
      default: v = 18'($urandom_range(0, 8191));
    endcase
    write_reg(pfrf_pkg::REG_RESERVE, v);
    case ($urandom_range(0, 5))
      0: v = 18'd0;
      1: v = 18'd32;
      2: v = 18'd63;
      default: v = 18'($urandom_range(1, 8));
    endcase
    write_reg(pfrf_pkg::REG_FRAME, v);
    case ($urandom_range(0, 6))
      0: v = 18'd1;
      1: v = 18'd64;
      2: v = 18'($urandom_range(65, 127));
      default: v = 18'($urandom_range(1, 16));
    endcase
    write_reg(pfrf_pkg::REG_CHUNK, v);
    write_reg(pfrf_pkg::REG_RESUME, 18'($urandom_range(0, 1)));
    case ($urandom_range(0, 3))
      0: v = 18'd0;
      1: v = 18'd192000;
      2: v = 18'h3FFFF;
      default: v = 18'($urandom_range(0, 262143));
    endcase
    write_reg(pfrf_pkg::REG_RATE, v);
    case ($urandom_range(0, 3))
      0: v = 18'd0;
      1: v = 18'd8;
      2: v = 18'd15;
      default: v = 18'($urandom_range(0, 15));
    endcase
    write_reg(pfrf_pkg::REG_CHANNELS, v);
  endtask

  task automatic test_random_traffic();
    int sent;
    int n;
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      shuffle_setup();
      sent = 0;
      while (sent < SEG_ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          // whole frames followed by a pop, trimmed to the segment budget
          n = int'(frame_r == 6'd0 ? 6'd1 : frame_r) * int'($urandom_range(0, 3));
          if (n > SEG_ITEMS - sent - 1)
            n = SEG_ITEMS - sent - 1;
          push_random(n);
          pop_chunk();
          sent += n + 1;
        end else begin
          send_item(pfrf_pkg::func_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
          sent++;
        end
        if ($urandom_range(0, 39) == 0)
          settle_results();
      end
      settle_results();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_frame_clamp();
    test_empty_pops();
    test_oversized_chunk();
    test_reserve();
    test_prefill();
    test_random_traffic();
    settle_results();
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("** pcm_frame_ring_fifo: PASSED **");
    else
      $display("** pcm_frame_ring_fifo: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/pfrf_pkg.sv
src/pfrf_ring_mem.sv
src/pfrf_frame_div.sv
src/pcm_frame_ring_fifo.sv
sim/pcm_frame_ring_fifo_tb.sv
